// ===== sv/rwu_pkg.sv =====
// ----------------------------------------------------------------------------
// rwu_pkg
// Shared types, constants and step functions for the RMSprop weight updater.
// ----------------------------------------------------------------------------
package rwu_pkg;

  localparam int Depth  = 4096;
  localparam int AddrW  = $clog2(Depth);
  localparam int RootW  = 24;
  localparam int DenW   = 25;
  localparam int NumW   = 36;
  localparam int QuotW  = 18;
  localparam int RemSqW = 27;

  // Configuration register indexes.
  localparam logic [7:0] CFG_LEARNING_RATE = 8'd0;
  localparam logic [7:0] CFG_DECAY         = 8'd1;
  localparam logic [7:0] CFG_EPSILON       = 8'd2;
  localparam logic [7:0] CFG_WEIGHT_LIMIT  = 8'd3;

  typedef struct packed {
    logic [11:0]        weight_index;
    logic signed [15:0] weight;
    logic signed [15:0] gradient;
  } in_beat_t;

  typedef struct packed {
    logic [11:0]        out_index;
    logic signed [15:0] new_weight;
  } out_beat_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] learning_rate;
    logic [15:0] decay;
    logic [23:0] epsilon;
    logic [14:0] weight_limit;
  } cfg_t;

  // Per-item data carried alongside the arithmetic.
  typedef struct packed {
    logic [11:0]        idx;
    logic signed [15:0] w;
    logic               gneg;
    logic [NumW-1:0]    num;
  } tag_t;

  // One digit-pair step of the integer square root: returns {rem, root}.
  function automatic logic [RemSqW+RootW-1:0] sqrt_step(input logic [RemSqW-1:0] rem,
                                                        input logic [RootW-1:0]  root,
                                                        input logic [1:0]        pair);
    logic [RemSqW-1:0] r;
    logic [RemSqW-1:0] t;
    logic [RootW-1:0]  q;
    r = {rem[RemSqW-3:0], pair};
    t = {1'b0, root, 2'b01};
    if (r >= t) begin
      r = r - t;
      q = {root[RootW-2:0], 1'b1};
    end else begin
      q = {root[RootW-2:0], 1'b0};
    end
    return {r, q};
  endfunction

  // One bit of restoring division: returns {rem, quotient bit}.
  function automatic logic [DenW:0] div_step(input logic [DenW-1:0] rem,
                                             input logic            nbit,
                                             input logic [DenW-1:0] den);
    logic [DenW:0] r;
    logic          q;
    r = {rem, nbit};
    if (r >= {1'b0, den}) begin
      r = r - {1'b0, den};
      q = 1'b1;
    end else begin
      q = 1'b0;
    end
    return {r[DenW-1:0], q};
  endfunction

endpackage

// ===== sv/rwu_ms_stage.sv =====
// ----------------------------------------------------------------------------
// rwu_ms_stage
// Mean-square store with clearing pass, read-modify-write pipeline and
// forwarding of the newest write.
// ----------------------------------------------------------------------------
module rwu_ms_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             acc_v,
  input  rwu_pkg::in_beat_t in_beat,
  input  rwu_pkg::cfg_t    cfg,
  output logic             clearing,
  output logic             ms_v,
  output logic [47:0]      ms_val,
  output rwu_pkg::tag_t    ms_tag
);

  logic [47:0] mem [rwu_pkg::Depth];

  logic                      clr_r;
  logic [rwu_pkg::AddrW-1:0] clr_cnt_r;

  logic               p0_v_r;
  logic [11:0]        p0_idx_r;
  logic signed [15:0] p0_w_r;
  logic               p0_gneg_r;
  logic [15:0]        p0_mag_r;

  logic          p1_v_r;
  rwu_pkg::tag_t p1_tag_r;
  logic [30:0]   p1_mag2_r;

  logic          p2_v_r;
  rwu_pkg::tag_t p2_tag_r;
  logic [47:0]   p2_term_r;
  logic [47:0]   p2_rd_r;

  logic          p3_v_r;
  rwu_pkg::tag_t p3_tag_r;
  logic [47:0]   p3_ms_r;

  logic [15:0] mag;
  logic [47:0] ms_old;
  logic [64:0] acc;
  logic [47:0] ms_nxt;

  // Gradient magnitude of the incoming beat.
  assign mag = in_beat.gradient[15] ? (~in_beat.gradient + 16'd1) : in_beat.gradient;

  // Clearing pass after reset, one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == {rwu_pkg::AddrW{1'b1}}) begin
        clr_r <= 1'b0;
      end
    end
  end

  assign clearing = clr_r;

  // Update: older value comes from the item just ahead if it hit the same slot.
  always_comb begin
    ms_old = (p3_v_r && (p3_tag_r.idx == p2_tag_r.idx)) ? p3_ms_r : p2_rd_r;
    acc    = 65'(48'(cfg.decay) * ms_old) + 65'({p2_term_r, 16'd0}) + 65'd32768;
    ms_nxt = acc[63:16];
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (adv && p2_v_r) begin
      mem[p2_tag_r.idx[rwu_pkg::AddrW-1:0]] <= ms_nxt;
    end
    if (adv) begin
      p2_rd_r <= mem[p1_tag_r.idx[rwu_pkg::AddrW-1:0]];
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else if (adv) begin
      p0_v_r <= acc_v;
      p1_v_r <= p0_v_r;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      p0_idx_r  <= in_beat.weight_index;
      p0_w_r    <= in_beat.weight;
      p0_gneg_r <= in_beat.gradient[15];
      p0_mag_r  <= mag;

      p1_tag_r.idx  <= p0_idx_r;
      p1_tag_r.w    <= p0_w_r;
      p1_tag_r.gneg <= p0_gneg_r;
      p1_tag_r.num  <= {32'(p0_mag_r * cfg.learning_rate), 4'd0};
      p1_mag2_r     <= 31'(p0_mag_r * p0_mag_r);

      p2_tag_r  <= p1_tag_r;
      p2_term_r <= 48'((17'h10000 - 17'(cfg.decay)) * p1_mag2_r);

      p3_tag_r <= p2_tag_r;
      p3_ms_r  <= ms_nxt;
    end
  end

  assign ms_v   = p3_v_r;
  assign ms_val = p3_ms_r;
  assign ms_tag = p3_tag_r;

endmodule

// ===== sv/rwu_sqrt.sv =====
// ----------------------------------------------------------------------------
// rwu_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rwu_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_v,
  input  logic [47:0]                in_val,
  input  rwu_pkg::tag_t              in_tag,
  output logic                       out_v,
  output logic [rwu_pkg::RootW-1:0]  out_root,
  output rwu_pkg::tag_t              out_tag
);

  localparam int N = rwu_pkg::RootW;

  logic                       v_r    [N];
  logic [rwu_pkg::RemSqW-1:0] rem_r  [N];
  logic [N-1:0]               root_r [N];
  logic [47:0]                val_r  [N];
  rwu_pkg::tag_t              tag_r  [N];

  logic [rwu_pkg::RemSqW+N-1:0] step [N];

  // Each stage consumes one pair of radicand bits, most significant first.
  always_comb begin
    step[0] = rwu_pkg::sqrt_step('0, '0, in_val[47:46]);
    for (int k = 1; k < N; k++) begin
      step[k] = rwu_pkg::sqrt_step(rem_r[k-1], root_r[k-1], val_r[k-1][47-2*k -: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_v;
      for (int k = 1; k < N; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {rem_r[0], root_r[0]} <= step[0];
      val_r[0] <= in_val;
      tag_r[0] <= in_tag;
      for (int k = 1; k < N; k++) begin
        {rem_r[k], root_r[k]} <= step[k];
        val_r[k] <= val_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  assign out_v    = v_r[N-1];
  assign out_root = root_r[N-1];
  assign out_tag  = tag_r[N-1];

endmodule

// ===== sv/rwu_div.sv =====
// ----------------------------------------------------------------------------
// rwu_div
// Step computation: rounded lr*g/(root+eps) by a pipelined restoring divider,
// then subtraction from the weight and symmetric clamp.
// ----------------------------------------------------------------------------
module rwu_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_v,
  input  logic [rwu_pkg::RootW-1:0] in_root,
  input  rwu_pkg::tag_t             in_tag,
  input  rwu_pkg::cfg_t             cfg,
  output logic                      out_v,
  output rwu_pkg::out_beat_t        out_beat
);

  localparam int Q  = rwu_pkg::QuotW;
  localparam int DW = rwu_pkg::DenW;
  localparam int NW = rwu_pkg::NumW + 1;

  logic [DW-1:0] den;
  logic [NW-1:0] nsum;

  // Front stage: denominator, rounded numerator, overflow and zero flags.
  logic          d0_v_r;
  logic [DW-1:0] d0_den_r;
  logic [NW-1:0] d0_n_r;
  logic [DW-1:0] d0_rem_r;
  logic          d0_zero_r;
  logic          d0_ovf_r;
  rwu_pkg::tag_t d0_tag_r;

  // Divider stages.
  logic          v_r    [Q];
  logic [DW-1:0] den_r  [Q];
  logic [NW-1:0] n_r    [Q];
  logic [DW-1:0] rem_r  [Q];
  logic [Q-1:0]  q_r    [Q];
  logic          zero_r [Q];
  logic          ovf_r  [Q];
  rwu_pkg::tag_t tag_r  [Q];

  logic [DW:0] step [Q];

  logic [Q-1:0]       stepmag;
  logic signed [19:0] sstep;
  logic signed [19:0] nw;
  logic signed [19:0] lim;
  logic signed [19:0] clamped;

  assign den  = DW'(in_root) + DW'(cfg.epsilon);
  assign nsum = NW'(in_tag.num) + NW'(den[DW-1:1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_den_r  <= den;
      d0_n_r    <= nsum;
      d0_rem_r  <= DW'(nsum[NW-1:Q]);
      d0_zero_r <= (den == '0);
      d0_ovf_r  <= (DW'(nsum[NW-1:Q]) >= den);
      d0_tag_r  <= in_tag;
    end
  end

  // One quotient bit per stage, most significant first.
  always_comb begin
    step[0] = rwu_pkg::div_step(d0_rem_r, d0_n_r[Q-1], d0_den_r);
    for (int k = 1; k < Q; k++) begin
      step[k] = rwu_pkg::div_step(rem_r[k-1], n_r[k-1][Q-1-k], den_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_v_r <= 1'b0;
      for (int k = 0; k < Q; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      d0_v_r <= in_v;
      v_r[0] <= d0_v_r;
      for (int k = 1; k < Q; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= step[0][DW:1];
      q_r[0]    <= {{(Q-1){1'b0}}, step[0][0]};
      den_r[0]  <= d0_den_r;
      n_r[0]    <= d0_n_r;
      zero_r[0] <= d0_zero_r;
      ovf_r[0]  <= d0_ovf_r;
      tag_r[0]  <= d0_tag_r;
      for (int k = 1; k < Q; k++) begin
        rem_r[k]  <= step[k][DW:1];
        q_r[k]    <= {q_r[k-1][Q-2:0], step[k][0]};
        den_r[k]  <= den_r[k-1];
        n_r[k]    <= n_r[k-1];
        zero_r[k] <= zero_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        tag_r[k]  <= tag_r[k-1];
      end
    end
  end

  // Apply the step; a saturated quotient always drives the weight to the bound.
  always_comb begin
    if (zero_r[Q-1]) begin
      stepmag = '0;
    end else if (ovf_r[Q-1]) begin
      stepmag = '1;
    end else begin
      stepmag = q_r[Q-1];
    end
    sstep = tag_r[Q-1].gneg ? -$signed(20'(stepmag)) : $signed(20'(stepmag));
    nw    = 20'(tag_r[Q-1].w) - sstep;
    lim   = $signed(20'(cfg.weight_limit));
    if (nw > lim) begin
      clamped = lim;
    end else if (nw < -lim) begin
      clamped = -lim;
    end else begin
      clamped = nw;
    end
  end

  assign out_v               = v_r[Q-1];
  assign out_beat.out_index  = tag_r[Q-1].idx;
  assign out_beat.new_weight = clamped[15:0];

endmodule

// ===== sv/rmsprop_weight_update.sv =====
// ----------------------------------------------------------------------------
// rmsprop_weight_update
// Per-weight RMSprop update with a per-index running mean square.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready) carry a weight index, the weight and its
//   gradient; each produces exactly one output beat (out_valid/out_ready)
//   with the index and the updated, clamped weight, in order.
//   Configuration beats (cfg_valid/cfg_ready, always ready) write learning
//   rate, decay, epsilon and weight limit; write them only while idle.
// Throughput: one beat per cycle while out_ready is high; same-index beats
//   may follow back to back as the newest mean-square write is forwarded.
// Pipeline: from input acceptance to output valid a beat passes the
//   mean-square update stages, 24 square-root stages, 19 divider stages and
//   the output register.
// Reset: configuration and valid registers return to their defaults and a
//   clearing pass zeroes the 4096-entry mean-square memory, one entry per
//   cycle; in_ready stays low until the pass is done.
// Stall: when out_ready is low with a beat waiting, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rmsprop_weight_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rwu_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output rwu_pkg::out_beat_t  out_beat,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  rwu_pkg::cfg_t cfg_r;

  logic adv;
  logic clearing;

  logic                      ms_v;
  logic [47:0]               ms_val;
  rwu_pkg::tag_t             ms_tag;
  logic                      sq_v;
  logic [rwu_pkg::RootW-1:0] sq_root;
  rwu_pkg::tag_t             sq_tag;
  logic                      dv_v;
  rwu_pkg::out_beat_t        dv_beat;

  logic               out_valid_r;
  rwu_pkg::out_beat_t out_beat_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv && !clearing;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learning_rate <= 16'd655;
      cfg_r.decay         <= 16'd64880;
      cfg_r.epsilon       <= 24'd105;
      cfg_r.weight_limit  <= 15'd20480;
    end else if (cfg_valid) begin
      case (cfg_index)
        rwu_pkg::CFG_LEARNING_RATE: cfg_r.learning_rate <= cfg_data[15:0];
        rwu_pkg::CFG_DECAY:         cfg_r.decay         <= cfg_data[15:0];
        rwu_pkg::CFG_EPSILON:       cfg_r.epsilon       <= cfg_data[23:0];
        rwu_pkg::CFG_WEIGHT_LIMIT:  cfg_r.weight_limit  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  rwu_ms_stage u_ms (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .acc_v    (in_valid && in_ready),
    .in_beat  (in_beat),
    .cfg      (cfg_r),
    .clearing (clearing),
    .ms_v     (ms_v),
    .ms_val   (ms_val),
    .ms_tag   (ms_tag)
  );

  rwu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (ms_v),
    .in_val   (ms_val),
    .in_tag   (ms_tag),
    .out_v    (sq_v),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  rwu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (sq_v),
    .in_root  (sq_root),
    .in_tag   (sq_tag),
    .cfg      (cfg_r),
    .out_v    (dv_v),
    .out_beat (dv_beat)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_beat_r <= dv_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule
